// File: rtl/core/datagram_transport_engine_unit_defines.svh
// Assertion helpers used by the controller of the datagram transport engine.
`ifndef DATAGRAM_TRANSPORT_ENGINE_UNIT_DEFINES_SVH
`define DATAGRAM_TRANSPORT_ENGINE_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define DTEU_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define DTEU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/core/dteu_pkg.sv
`default_nettype none
package dteu_pkg;

    localparam int DEF_MAX_BYTES = 72;
    localparam int CFG_IDX_W = 4;
    localparam logic [15:0] NAK_CODE_BUF_FULL = 16'h2020;
    localparam logic [15:0] DEF_ACK_TIMEOUT = 16'd2000;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE_ID = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        REQ_TICK  = 3'd0,
        REQ_FRAME = 3'd1,
        REQ_ACK   = 3'd2,
        REQ_NAK   = 3'd3,
        REQ_SEND  = 3'd4,
        REQ_OTHER = 3'd5
    } t_req_kind;

    typedef enum logic [3:0] {
        EV_IGNORED   = 4'd0,
        EV_STORED    = 4'd1,
        EV_RX_CHUNK  = 4'd2,
        EV_SEND_ACK  = 4'd3,
        EV_NAK_REJ   = 4'd4,
        EV_NAK_BUSY  = 4'd5,
        EV_TX_TAKEN  = 4'd6,
        EV_TX_BUSY   = 4'd7,
        EV_TX_OK     = 4'd8,
        EV_NAK_RETRY = 4'd9,
        EV_NAK_GIVE  = 4'd10,
        EV_FRAG_PROG = 4'd11,
        EV_ALL_SENT  = 4'd12,
        EV_ABORTED   = 4'd13,
        EV_ACK_TMO   = 4'd14,
        EV_IDLE      = 4'd15
    } t_event;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_WR,
        S_RA,
        S_RC,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [47:0] dest_node;
        logic [47:0] src_node;
        logic [3:0]  frame_len;
        logic [63:0] frame_data;
        logic        is_last;
        logic [15:0] nak_code;
        logic        accept;
        logic [6:0]  tx_length;
        logic [3:0]  sent_count;
    } t_req;

    typedef struct packed {
        t_event      event_res;
        logic [47:0] peer_node;
        logic [15:0] error_code;
        logic [63:0] data_chunk;
        logic [3:0]  chunk_bytes;
        logic        last;
    } t_res;

    typedef struct packed {
        logic capture;
        logic eval_single;
        logic rx_start;
        logic wr_step;
        logic ld_stored;
        logic rd_start;
        logic rd_first;
        logic rd_next;
        logic rd_capture;
        logic ld_final;
    } t_cmd;

    typedef struct packed {
        logic frame_go;
        logic wr_done;
        logic is_last;
        logic nonempty;
        logic rd_more;
        logic chunk_end;
        logic res_last;
    } t_st;

endpackage
`default_nettype wire

// File: rtl/core/dteu_if.sv
`default_nettype none
interface dteu_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [47:0] dest_node;
    logic [47:0] src_node;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic        is_last;
    logic [15:0] nak_code;
    logic        accept;
    logic [6:0]  tx_length;
    logic [3:0]  sent_count;
    modport source (output valid, req_type, dest_node, src_node, frame_len, frame_data,
                    is_last, nak_code, accept, tx_length, sent_count, input ready);
    modport sink (input valid, req_type, dest_node, src_node, frame_len, frame_data,
                  is_last, nak_code, accept, tx_length, sent_count, output ready);
endinterface

interface dteu_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  event_res;
    logic [47:0] peer_node;
    logic [15:0] error_code;
    logic [63:0] data_chunk;
    logic [3:0]  chunk_bytes;
    logic [6:0]  tx_offset_out;
    logic        last;
    modport source (output valid, event_res, peer_node, error_code, data_chunk,
                    chunk_bytes, tx_offset_out, last, input ready);
    modport sink (input valid, event_res, peer_node, error_code, data_chunk,
                  chunk_bytes, tx_offset_out, last, output ready);
endinterface

interface dteu_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/dteu_ram.sv
`default_nettype none
module dteu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 72
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/core/dteu_dpath.sv
`default_nettype none
module dteu_dpath #(
    parameter int MAX_BYTES = dteu_pkg::DEF_MAX_BYTES
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire dteu_pkg::t_req          i_req,
    input  wire logic                    i_cfg_we,
    input  wire logic [dteu_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [63:0]             i_cfg_data,
    input  wire dteu_pkg::t_cmd          i_cmd,
    output      dteu_pkg::t_st           o_st,
    output      dteu_pkg::t_res          o_res,
    output      logic [6:0]              o_tx_offset
);
    import dteu_pkg::*;

    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam int AW = $clog2(MAX_BYTES);

    t_req        r_req;
    logic [47:0] r_own_id;
    logic [15:0] r_timeout;
    logic        r_rx_free, n_rx_free;
    logic [47:0] r_rx_peer, n_rx_peer;
    logic [CW-1:0] r_rx_count, n_rx_count;
    logic        r_rx_ovf, n_rx_ovf;
    logic        r_tx_free, n_tx_free;
    logic        r_tx_active, n_tx_active;
    logic [6:0]  r_tx_offset, n_tx_offset;
    logic [6:0]  r_tx_total, n_tx_total;
    logic [15:0] r_elapsed, n_elapsed;
    logic [3:0]  r_wr_idx, n_wr_idx;
    logic [CW-1:0] r_rd_ptr, n_rd_ptr;
    logic [2:0]  r_bpos, n_bpos;
    t_res        r_res, n_res;

    logic        addressed;
    logic [3:0]  len8;
    logic [3:0]  sent8;
    logic [15:0] el1;
    logic [7:0]  tx_len_ext;
    logic        room;
    logic        ram_we;
    logic [7:0]  ram_rdata;

    assign addressed  = (r_own_id != 48'd0) && (r_req.dest_node == r_own_id);
    assign len8       = (r_req.frame_len > 4'd8) ? 4'd8 : r_req.frame_len;
    assign sent8      = (r_req.sent_count > 4'd8) ? 4'd8 : r_req.sent_count;
    assign el1        = (r_elapsed == 16'hFFFF) ? r_elapsed : r_elapsed + 16'd1;
    assign tx_len_ext = {1'b0, r_req.tx_length};
    assign room       = r_rx_count < CW'(MAX_BYTES);
    assign ram_we     = i_cmd.wr_step && (r_wr_idx != len8) && room;

    dteu_ram #(.WIDTH(8), .DEPTH(MAX_BYTES)) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_rx_count[AW-1:0]),
        .i_wdata (r_req.frame_data[8*r_wr_idx[2:0] +: 8]),
        .i_raddr (r_rd_ptr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_rx_free   = r_rx_free;
        n_rx_peer   = r_rx_peer;
        n_rx_count  = r_rx_count;
        n_rx_ovf    = r_rx_ovf;
        n_tx_free   = r_tx_free;
        n_tx_active = r_tx_active;
        n_tx_offset = r_tx_offset;
        n_tx_total  = r_tx_total;
        n_elapsed   = r_elapsed;
        n_wr_idx    = r_wr_idx;
        n_rd_ptr    = r_rd_ptr;
        n_bpos      = r_bpos;
        n_res       = r_res;

        if (i_cmd.eval_single) begin
            n_res = '{event_res: EV_IGNORED, peer_node: 48'd0, error_code: 16'd0,
                      data_chunk: 64'd0, chunk_bytes: 4'd0, last: 1'b1};
            unique case (r_req.req_type)
                REQ_TICK: begin
                    n_elapsed = el1;
                    if (r_tx_active) begin
                        if (sent8 == 4'd0 && el1 > r_timeout) begin
                            n_tx_free       = 1'b1;
                            n_tx_active     = 1'b0;
                            n_res.event_res = EV_ABORTED;
                        end else if (8'(r_tx_offset) + 8'(sent8) >= 8'(r_tx_total)) begin
                            n_tx_active     = 1'b0;
                            n_tx_offset     = 7'd0;
                            n_elapsed       = 16'd0;
                            n_res.event_res = EV_ALL_SENT;
                        end else begin
                            n_tx_offset     = r_tx_offset + 7'(sent8);
                            n_res.event_res = EV_FRAG_PROG;
                        end
                    end else if (!r_tx_free && el1 > r_timeout) begin
                        n_tx_free       = 1'b1;
                        n_res.event_res = EV_ACK_TMO;
                    end else begin
                        n_res.event_res = EV_IDLE;
                    end
                end
                REQ_FRAME: begin
                    // A frame that reaches here was either not for us or came
                    // from a second peer while a datagram is being gathered.
                    if (addressed) begin
                        n_res.event_res = EV_NAK_BUSY;
                        n_res.peer_node = r_req.src_node;
                    end
                end
                REQ_ACK: begin
                    if (addressed) begin
                        n_tx_free       = 1'b1;
                        n_tx_active     = 1'b0;
                        n_tx_offset     = 7'd0;
                        n_res.event_res = EV_TX_OK;
                        n_res.peer_node = r_req.src_node;
                    end
                end
                REQ_NAK: begin
                    if (addressed) begin
                        n_tx_offset      = 7'd0;
                        n_res.peer_node  = r_req.src_node;
                        n_res.error_code = r_req.nak_code;
                        if (r_req.nak_code == NAK_CODE_BUF_FULL) begin
                            n_tx_active     = 1'b1;
                            n_res.event_res = EV_NAK_RETRY;
                        end else begin
                            n_tx_active     = 1'b0;
                            n_tx_free       = 1'b1;
                            n_res.event_res = EV_NAK_GIVE;
                        end
                    end
                end
                REQ_SEND: begin
                    if (!r_tx_free) begin
                        n_res.event_res = EV_TX_BUSY;
                    end else begin
                        n_tx_total      = (tx_len_ext > 8'(MAX_BYTES)) ? 7'(MAX_BYTES)
                                                                       : r_req.tx_length;
                        n_tx_free       = 1'b0;
                        n_tx_active     = 1'b1;
                        n_tx_offset     = 7'd0;
                        n_elapsed       = 16'd0;
                        n_res.event_res = EV_TX_TAKEN;
                    end
                end
                default: begin
                    n_res.event_res = EV_IGNORED;
                end
            endcase
        end

        if (i_cmd.rx_start) begin
            n_wr_idx = 4'd0;
            if (r_rx_free) begin
                n_rx_free  = 1'b0;
                n_rx_count = '0;
                n_rx_ovf   = 1'b0;
                n_rx_peer  = r_req.src_node;
            end
        end

        if (i_cmd.wr_step && r_wr_idx != len8) begin
            n_wr_idx = r_wr_idx + 4'd1;
            if (room) begin
                n_rx_count = r_rx_count + CW'(1);
            end else begin
                n_rx_ovf = 1'b1;
            end
        end

        if (i_cmd.ld_stored) begin
            n_res = '{event_res: EV_STORED, peer_node: 48'd0, error_code: 16'd0,
                      data_chunk: 64'd0, chunk_bytes: 4'd0, last: 1'b1};
        end

        if (i_cmd.rd_start) begin
            n_rd_ptr = '0;
        end

        if (i_cmd.rd_first) begin
            n_res = '{event_res: EV_RX_CHUNK, peer_node: 48'd0, error_code: 16'd0,
                      data_chunk: 64'd0, chunk_bytes: 4'd0, last: 1'b0};
            n_bpos   = 3'd0;
            n_rd_ptr = r_rd_ptr + CW'(1);
        end

        if (i_cmd.rd_capture) begin
            n_res.data_chunk[8*r_bpos +: 8] = ram_rdata;
            n_res.chunk_bytes               = 4'(r_bpos) + 4'd1;
            n_bpos                          = r_bpos + 3'd1;
        end

        if (i_cmd.rd_next) begin
            n_rd_ptr = r_rd_ptr + CW'(1);
        end

        if (i_cmd.ld_final) begin
            n_res = '{event_res: (r_req.accept && !r_rx_ovf) ? EV_SEND_ACK : EV_NAK_REJ,
                      peer_node: r_rx_peer, error_code: 16'd0,
                      data_chunk: 64'd0, chunk_bytes: 4'd0, last: 1'b1};
            n_rx_free = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id    <= 48'd0;
            r_timeout   <= DEF_ACK_TIMEOUT;
            r_rx_free   <= 1'b1;
            r_rx_peer   <= 48'd0;
            r_rx_count  <= '0;
            r_rx_ovf    <= 1'b0;
            r_tx_free   <= 1'b1;
            r_tx_active <= 1'b0;
            r_tx_offset <= 7'd0;
            r_tx_total  <= 7'd0;
            r_elapsed   <= 16'd0;
        end else begin
            if (i_cfg_we && i_cfg_idx == CFG_OWN_NODE_ID) begin
                r_own_id <= i_cfg_data[47:0];
            end
            if (i_cfg_we && i_cfg_idx == CFG_ACK_TIMEOUT) begin
                r_timeout <= i_cfg_data[15:0];
            end
            r_rx_free   <= n_rx_free;
            r_rx_peer   <= n_rx_peer;
            r_rx_count  <= n_rx_count;
            r_rx_ovf    <= n_rx_ovf;
            r_tx_free   <= n_tx_free;
            r_tx_active <= n_tx_active;
            r_tx_offset <= n_tx_offset;
            r_tx_total  <= n_tx_total;
            r_elapsed   <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        r_wr_idx <= n_wr_idx;
        r_rd_ptr <= n_rd_ptr;
        r_bpos   <= n_bpos;
        r_res    <= n_res;
    end

    assign o_st.frame_go  = (r_req.req_type == REQ_FRAME) && addressed
                            && (r_rx_free || r_req.src_node == r_rx_peer);
    assign o_st.wr_done   = (r_wr_idx == len8);
    assign o_st.is_last   = r_req.is_last;
    assign o_st.nonempty  = (r_rx_count != '0);
    assign o_st.rd_more   = (r_rd_ptr < r_rx_count);
    assign o_st.chunk_end = (r_bpos == 3'd7);
    assign o_st.res_last  = r_res.last;
    assign o_res          = r_res;
    assign o_tx_offset    = r_tx_offset;
endmodule
`default_nettype wire

// File: rtl/core/dteu_ctrl.sv
`default_nettype none
`include "datagram_transport_engine_unit_defines.svh"
module dteu_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output      logic          o_in_ready,
    output      logic          o_out_valid,
    input  wire logic          i_out_ready,
    input  wire dteu_pkg::t_st i_st,
    output      dteu_pkg::t_cmd o_cmd
);
    import dteu_pkg::*;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_EVAL;
            S_EVAL: n_state = i_st.frame_go ? S_WR : S_OUT;
            S_WR: begin
                if (i_st.wr_done) begin
                    n_state = (i_st.is_last && i_st.nonempty) ? S_RA : S_OUT;
                end
            end
            S_RA: n_state = S_RC;
            S_RC: if (!(i_st.rd_more && !i_st.chunk_end)) n_state = S_OUT;
            S_FIN: n_state = S_OUT;
            S_OUT: begin
                if (i_out_ready) begin
                    if (i_st.res_last) begin
                        n_state = S_IDLE;
                    end else if (i_st.rd_more) begin
                        n_state = S_RA;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EVAL: begin
                o_cmd.rx_start    = i_st.frame_go;
                o_cmd.eval_single = !i_st.frame_go;
            end
            S_WR: begin
                if (!i_st.wr_done) begin
                    o_cmd.wr_step = 1'b1;
                end else if (!i_st.is_last) begin
                    o_cmd.ld_stored = 1'b1;
                end else if (i_st.nonempty) begin
                    o_cmd.rd_start = 1'b1;
                end else begin
                    o_cmd.ld_final = 1'b1;
                end
            end
            S_RA: o_cmd.rd_first = 1'b1;
            S_RC: begin
                o_cmd.rd_capture = 1'b1;
                o_cmd.rd_next    = i_st.rd_more && !i_st.chunk_end;
            end
            S_FIN: o_cmd.ld_final = 1'b1;
            S_OUT: o_out_valid = 1'b1;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `DTEU_ASSERT_CLK(a_take_to_eval, (o_in_ready && i_in_valid) |=> (r_state == S_EVAL), "accepted beat did not start evaluation")
    `DTEU_ASSERT_ALWAYS(a_no_overlap, !(o_in_ready && o_out_valid), "input ready while a result is shown")
    `DTEU_ASSERT_CLK(a_last_to_idle, (o_out_valid && i_out_ready && i_st.res_last) |=> o_in_ready, "final result did not return to idle")
endmodule
`default_nettype wire

// File: rtl/core/datagram_transport_engine_unit.sv
// Flow: a request beat is captured while idle, evaluated, and its result is shown until taken;
// a frame first writes its payload into the store byte by byte. A completed datagram reads
// back byte by byte into 8-byte chunks, each shown in turn, then the closing ack or nak.
// Requests are taken one at a time: a new beat is accepted only after the last result of
// the previous one is taken, and the byte-wide store paces frames and datagrams.
// Reset (i_rst_n low, synchronous) frees both sides, clears counters and the node id.
`default_nettype none
module datagram_transport_engine_unit #(
    parameter int MAX_BYTES = dteu_pkg::DEF_MAX_BYTES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    dteu_req_if.sink   i_in,
    dteu_res_if.source o_out,
    dteu_cfg_if.sink   i_cfg
);
    import dteu_pkg::*;

    // Request beats are captured in the datapath and worked on one at a time.
    // The controller sequences the byte-serial writes into the receive store
    // and the byte-serial read-back that builds each 8-byte chunk.
    // Reset also loads a 2000 tick timeout; the store holds no reset value.
    t_req       req;
    t_cmd       cmd;
    t_st        st;
    t_res       res;
    logic [6:0] tx_offset;

    assign req = '{req_type: i_in.req_type, dest_node: i_in.dest_node,
                   src_node: i_in.src_node, frame_len: i_in.frame_len,
                   frame_data: i_in.frame_data, is_last: i_in.is_last,
                   nak_code: i_in.nak_code, accept: i_in.accept,
                   tx_length: i_in.tx_length, sent_count: i_in.sent_count};

    // Configuration writes are always taken; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    dteu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_st        (st),
        .o_cmd       (cmd)
    );

    dteu_dpath #(.MAX_BYTES(MAX_BYTES)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_idx   (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_cmd       (cmd),
        .o_st        (st),
        .o_res       (res),
        .o_tx_offset (tx_offset)
    );

    // The result register is held while the sink stalls.
    assign o_out.event_res     = res.event_res;
    assign o_out.peer_node     = res.peer_node;
    assign o_out.error_code    = res.error_code;
    assign o_out.data_chunk    = res.data_chunk;
    assign o_out.chunk_bytes   = res.chunk_bytes;
    assign o_out.tx_offset_out = tx_offset;
    assign o_out.last          = res.last;
endmodule
`default_nettype wire
